[hdl/rfas_pkg.sv]
// Shared types, field bounds and helpers for the RTC field adjust and sanitize unit.
package rfas_pkg;

	// opcodes
	localparam logic [1:0] OP_SANITIZE = 2'd0;
	localparam logic [1:0] OP_INC      = 2'd1;
	localparam logic [1:0] OP_DEC      = 2'd2;

	// field bounds
	localparam logic [7:0] YEAR_MAX    = 8'd99;
	localparam logic [7:0] MONTH_MAX   = 8'd12;
	localparam logic [7:0] WEEKDAY_MAX = 8'd6;
	localparam logic [7:0] HOUR_MAX    = 8'd23;
	localparam logic [7:0] MINSEC_MAX  = 8'd59;
	localparam logic [7:0] FEB         = 8'd2;

	// payload traveling down the pipe
	typedef struct packed {
		logic        is_date;
		logic [31:0] word;
	} stage_t;

	// lower bound minus one wraps to upper, anything else out of range goes to lower
	function automatic logic [7:0] clamp_byte(input logic [7:0] v, input logic [7:0] upper,
		input logic [7:0] lower);
		logic [7:0] lm1;
		logic [7:0] up1;
		lm1 = lower - 8'd1;
		up1 = upper + 8'd1;
		if (v == lm1) begin
			clamp_byte = upper;
		end else if (v >= up1 || v < lower) begin
			clamp_byte = lower;
		end else begin
			clamp_byte = v;
		end
	endfunction

	// day count of a sanitized month (1..12), leap February gets 29
	function automatic logic [7:0] month_days(input logic [7:0] month, input logic leap);
		logic [7:0] d;
		unique case (month)
			8'd2:                         d = 8'd28;
			8'd4, 8'd6, 8'd9, 8'd11:      d = 8'd30;
			default:                      d = 8'd31;
		endcase
		if (leap && month == FEB) begin
			d = 8'd29;
		end
		month_days = d;
	endfunction

endpackage

[hdl/rfas_step.sv]
// Stage 1: optional increment or decrement of one byte of the input word.
module rfas_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      opcode,
	input  logic            is_date,
	input  logic [1:0]      field_index,
	input  logic [31:0]     rtc_word,
	output logic            valid_s1,
	output rfas_pkg::stage_t data_s1
);
	import rfas_pkg::*;

	logic [31:0] stepped;

	// per-byte step, wraps within the byte
	always_comb begin
		stepped = rtc_word;
		for (int i = 0; i < 4; i++) begin
			if (field_index == 2'(i)) begin
				if (opcode == OP_INC) begin
					stepped[i*8 +: 8] = rtc_word[i*8 +: 8] + 8'd1;
				end else if (opcode == OP_DEC) begin
					stepped[i*8 +: 8] = rtc_word[i*8 +: 8] - 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.is_date <= is_date;
		data_s1.word    <= stepped;
	end
endmodule

[hdl/rfas_clamp.sv]
// Stage 2: sanitize year and month of a date, or hour, minute and second of a time.
module rfas_clamp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  rfas_pkg::stage_t data_s1,
	output logic             valid_s2,
	output rfas_pkg::stage_t data_s2
);
	import rfas_pkg::*;

	logic [31:0] w;

	// date: bytes 2 and 3 wait for stage 3; time: top byte passes untouched
	always_comb begin
		w = data_s1.word;
		if (data_s1.is_date) begin
			w[7:0]  = clamp_byte(data_s1.word[7:0],  YEAR_MAX,  8'd0);
			w[15:8] = clamp_byte(data_s1.word[15:8], MONTH_MAX, 8'd1);
		end else begin
			w[7:0]   = clamp_byte(data_s1.word[7:0],   HOUR_MAX,   8'd0);
			w[15:8]  = clamp_byte(data_s1.word[15:8],  MINSEC_MAX, 8'd0);
			w[23:16] = clamp_byte(data_s1.word[23:16], MINSEC_MAX, 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2.is_date <= data_s1.is_date;
		data_s2.word    <= w;
	end
endmodule

[hdl/rfas_day.sv]
// Stage 3: day limit from the sanitized month and year, then day and weekday sanitize.
module rfas_day (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s2,
	input  rfas_pkg::stage_t data_s2,
	output logic             valid_s3,
	output logic [31:0]      word_s3
);
	import rfas_pkg::*;

	logic        leap;
	logic [7:0]  limit;
	logic [31:0] w;

	// sanitized year is 0..99, so leap reduces to divisible by four (year 0 included)
	assign leap  = (data_s2.word[1:0] == 2'b00);
	assign limit = month_days(data_s2.word[15:8], leap);

	always_comb begin
		w = data_s2.word;
		if (data_s2.is_date) begin
			w[23:16] = clamp_byte(data_s2.word[23:16], limit,       8'd1);
			w[31:24] = clamp_byte(data_s2.word[31:24], WEEKDAY_MAX, 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		word_s3 <= w;
	end
endmodule

[hdl/rtc_field_adjust_sanitize_unit.sv]
// Top level of the RTC field adjust and sanitize unit.
//
//  channel   signals                                       direction
//  command   start, opcode, is_date, field_index, rtc_word  in, taken when start && !busy
//  result    done, clean_word                               out, one cycle per beat
//
// Three register stages: byte step, year/month or time sanitize, day and weekday sanitize.
// A beat passes the step, clamp and day registers in turn and then raises done for one
// cycle, with its result on clean_word in that same cycle.
// One beat can enter every cycle; busy stays low, nothing in the pipe waits on anything.
// Reset clears the stage valid bits only; no result leaves after reset until a new beat.
module rtc_field_adjust_sanitize_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic        is_date,
	input  logic [1:0]  field_index,
	input  logic [31:0] rtc_word,
	output logic        done,
	output logic [31:0] clean_word
);
	import rfas_pkg::*;

	logic   valid_s1;
	logic   valid_s2;
	stage_t data_s1;
	stage_t data_s2;

	// never stalls
	assign busy = 1'b0;

	rfas_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.is_date     (is_date),
		.field_index (field_index),
		.rtc_word    (rtc_word),
		.valid_s1    (valid_s1),
		.data_s1     (data_s1)
	);

	rfas_clamp u_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	rfas_day u_day (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (done),
		.word_s3  (clean_word)
	);
endmodule
